/* sv/lfu_pkg.sv */
package lfu_pkg;

  // default built table size
  localparam int DEF_MAX_ENTRIES = 16;

  // slot number and live count fields are sized for the largest table (256)
  localparam int SLOT_W = 8;
  localparam int LIVE_W = 9;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int USES_W  = 32;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } out_word_t;

  // running summary handed from cell to cell
  typedef struct packed {
    logic               active;
    logic               found;
    logic [SLOT_W-1:0]  found_slot;
    logic [DATA_W-1:0]  found_data;
    logic               free_ok;
    logic [SLOT_W-1:0]  free_slot;
    logic               victim_ok;
    logic [SLOT_W-1:0]  victim_slot;
    logic [USES_W-1:0]  victim_uses;
    logic [STAMP_W-1:0] victim_stamp;
    logic [LIVE_W-1:0]  live;
  } carry_t;

  // entry update broadcast to all cells
  typedef struct packed {
    logic               en;
    logic               insert;
    logic               wr_data;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

/* sv/lfu_cell.sv */
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] req_key,
  input  carry_t           carry_in,
  output carry_t           carry_out,
  input  upd_t             upd
);

  logic               valid_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  data_r;
  logic [USES_W-1:0]  uses_r;
  logic [STAMP_W-1:0] stamp_r;
  carry_t             carry_r;
  carry_t             carry_nxt;
  logic               match;
  logic               sel;

  assign match = valid_r && (key_r == req_key);
  assign sel   = upd.en && (upd.slot == SLOT_W'(IDX));

  always_comb begin
    carry_nxt = carry_in;
    if (carry_in.active) begin
      if (match && !carry_in.found) begin
        carry_nxt.found      = 1'b1;
        carry_nxt.found_slot = SLOT_W'(IDX);
        carry_nxt.found_data = data_r;
      end
      if (valid_r) begin
        carry_nxt.live = carry_in.live + LIVE_W'(1);
        // strict compares keep the lower slot on a full tie
        if (!carry_in.victim_ok || (uses_r < carry_in.victim_uses) ||
            ((uses_r == carry_in.victim_uses) && (stamp_r < carry_in.victim_stamp))) begin
          carry_nxt.victim_ok    = 1'b1;
          carry_nxt.victim_slot  = SLOT_W'(IDX);
          carry_nxt.victim_uses  = uses_r;
          carry_nxt.victim_stamp = stamp_r;
        end
      end else if (!carry_in.free_ok) begin
        carry_nxt.free_ok   = 1'b1;
        carry_nxt.free_slot = SLOT_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && upd.insert) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= upd.stamp;
      if (upd.insert) begin
        key_r  <= upd.key;
        data_r <= upd.value;
        uses_r <= USES_W'(1);
      end else begin
        if (upd.wr_data) begin
          data_r <= upd.value;
        end
        if (uses_r != '1) begin
          uses_r <= uses_r + USES_W'(1);
        end
      end
    end
  end

endmodule

/* sv/lfu_cache_policy.sv */
// lfu_cache_policy: key-value store with least-frequently-used replacement and
// least-recently-used tie break. each word on the input channel is a get or a
// put and gives exactly one result word (hit flag, and the stored value on a
// get hit). entries live in a row of MAX_ENTRIES cells; an access sends one
// summary word down the row, one cell per cycle, which gathers the key match,
// the first free slot, the live count and the victim (lowest use count, then
// oldest stamp, then lowest slot). the scan is launched from a register, the
// summary is registered in each cell, the decision is latched, and the commit
// applies the entry update and loads the output register. the input stays
// stalled until that commit, so a new word is taken only once the last one
// has committed. a commit waits while an earlier result is still stalled.
// capacity is clamped to 1..MAX_ENTRIES. valid bits clear at reset, so no
// clearing pass is needed
module lfu_cache_policy
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_CAPACITY = 1'b0;  // word index of the capacity register

  state_t             state_r, state_nxt;
  in_word_t           req_r;
  carry_t             start_r;
  carry_t             start_nxt;
  carry_t             chain [MAX_ENTRIES+1];
  upd_t               dec_upd_r, dec_upd_nxt;
  out_word_t          dec_out_r, dec_out_nxt;
  upd_t               upd;
  out_word_t          out_r;
  logic               out_valid_r;
  logic [CAP_W-1:0]   cap_r;
  logic [STAMP_W-1:0] clock_r;
  logic [LIVE_W-1:0]  eff_cap;
  logic               accept;
  logic               out_free;
  logic               commit;
  carry_t             last;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_r} : 32'd0;

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = LIVE_W'(1);
    end else if (LIVE_W'(cap_r) > LIVE_W'(MAX_ENTRIES)) begin
      eff_cap = LIVE_W'(MAX_ENTRIES);
    end else begin
      eff_cap = LIVE_W'(cap_r);
    end
  end

  // ---------------- handshake ----------------
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_COMMIT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  // scan launch word, live for one cycle
  always_comb begin
    start_nxt        = '0;
    start_nxt.active = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else begin
      start_r <= start_nxt;
    end
  end

  // ---------------- cell row ----------------
  assign chain[0] = start_r;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_key  (req_r.key),
      .carry_in (chain[g]),
      .carry_out(chain[g+1]),
      .upd      (upd)
    );
  end

  assign last = chain[MAX_ENTRIES];

  // ---------------- decision from the finished scan ----------------
  always_comb begin
    dec_upd_nxt = '0;
    dec_out_nxt = '0;
    dec_upd_nxt.key   = req_r.key;
    dec_upd_nxt.value = req_r.value;
    if (last.found) begin
      // hit: touch the entry, a put also overwrites its value
      dec_out_nxt.hit     = 1'b1;
      dec_upd_nxt.en      = 1'b1;
      dec_upd_nxt.slot    = last.found_slot;
      dec_upd_nxt.wr_data = (req_r.action == ACT_PUT);
      if (req_r.action == ACT_GET) begin
        dec_out_nxt.read_value = last.found_data;
      end
    end else if (req_r.action == ACT_PUT) begin
      // new key: evict when full, else lowest free slot
      dec_upd_nxt.en     = 1'b1;
      dec_upd_nxt.insert = 1'b1;
      if ((last.live >= eff_cap) && last.victim_ok) begin
        dec_upd_nxt.slot = last.victim_slot;
      end else if (last.free_ok) begin
        dec_upd_nxt.slot = last.free_slot;
      end else begin
        dec_upd_nxt.slot = last.victim_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && last.active) begin
      dec_upd_r <= dec_upd_nxt;
      dec_out_r <= dec_out_nxt;
    end
  end

  // update broadcast, stamped with the next access clock value
  always_comb begin
    upd       = dec_upd_r;
    upd.en    = dec_upd_r.en && commit;
    upd.stamp = clock_r + STAMP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
    end else if (upd.en) begin
      clock_r <= clock_r + STAMP_W'(1);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= dec_out_r;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last.active) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
